/* sv/bpa_pkg.sv */
// Shared types, codes and defaults of the buddy page allocator.
package bpa_pkg;

   // Defaults for the top-level parameters
   localparam int DEF_PAGE_COUNT = 8;
   localparam int DEF_PAGE_SHIFT = 12;

   // Base address after reset
   localparam logic [31:0] BASE_RESET = 32'h1000_0000;

   // Order field wide enough for the largest pool (128 pages, top order 7)
   localparam int ORDER_W = 3;

   typedef logic [1:0] kind_type;

   localparam kind_type KIND_COVERED = 2'd0;
   localparam kind_type KIND_FREE    = 2'd1;
   localparam kind_type KIND_ALLOC   = 2'd2;

   typedef struct packed {
      kind_type           kind;
      logic [ORDER_W-1:0] order;
   } tag_type;

   localparam logic CMD_ALLOC   = 1'b0;
   localparam logic CMD_RELEASE = 1'b1;

   localparam logic STATUS_OK     = 1'b0;
   localparam logic STATUS_NO_FIT = 1'b1;

endpackage

/* sv/buddy_page_allocator_core.sv */
// Buddy page allocator: sequencer over a page tag memory with one shared fit compare.
//
//   channel   ports                                          handshake
//   --------  ---------------------------------------------  --------------------------
//   request   req_command, req_request_bytes,                start & !busy
//             req_block_address
//   result    rsp_granted_address, rsp_status                rsp_strobe, one cycle
//   csr       csr_base_address                               csr_valid & csr_ready
//
// Allocate scans every tag (one read per cycle on read port 0, the last tag judged in
// ST_SCANEND), then writes once per split and once to mark the head. Release locates and
// frees the head in ST_RELADDR, ST_RELREAD and ST_RELFREE (ST_RELADDR alone outside the
// pool), then makes the merge pass: a read and a compare per buddy pair (PAGE_COUNT - 1
// pairs), plus a cover write per merge for the single write port. The result is registered;
// busy drops as the strobe rises. Reset is synchronous; per-page valid bits bring the tags
// up as one free top-order block, so no clearing pass runs. The receiver cannot stall.
module buddy_page_allocator_core
   import bpa_pkg::*;
#(
   parameter int PAGE_COUNT = DEF_PAGE_COUNT,
   parameter int PAGE_SHIFT = DEF_PAGE_SHIFT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_command,
   input  logic [15:0] req_request_bytes,
   input  logic [31:0] req_block_address,
   output logic        rsp_strobe,
   output logic [31:0] rsp_granted_address,
   output logic        rsp_status,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_base_address
);

   localparam int IDX_W   = $clog2(PAGE_COUNT);
   localparam int LO_W    = IDX_W + 1;
   localparam int BYTES_W = IDX_W + PAGE_SHIFT + 1;
   localparam int CMP_W   = (BYTES_W > 17) ? BYTES_W : 17;

   localparam int ST_W = 4;
   localparam logic [ST_W-1:0] ST_IDLE    = 4'd0;
   localparam logic [ST_W-1:0] ST_SCAN    = 4'd1;
   localparam logic [ST_W-1:0] ST_SCANEND = 4'd2;
   localparam logic [ST_W-1:0] ST_SPLIT   = 4'd3;
   localparam logic [ST_W-1:0] ST_RELADDR = 4'd4;
   localparam logic [ST_W-1:0] ST_RELREAD = 4'd5;
   localparam logic [ST_W-1:0] ST_RELFREE = 4'd6;
   localparam logic [ST_W-1:0] ST_MREAD   = 4'd7;
   localparam logic [ST_W-1:0] ST_MEVAL   = 4'd8;
   localparam logic [ST_W-1:0] ST_MCOVER  = 4'd9;

   // Sequencer and request state
   logic [ST_W-1:0]    state_ff,      state_in;
   logic [15:0]        want_ff,       want_in;
   logic [31:0]        addr_ff,       addr_in;
   logic [31:0]        base_ff,       base_in;
   logic [IDX_W-1:0]   scan_idx_ff,   scan_idx_in;
   logic [IDX_W-1:0]   rd_idx_ff,     rd_idx_in;
   logic               scan_live_ff,  scan_live_in;
   logic               found_ff,      found_in;
   logic [IDX_W-1:0]   best_ff,       best_in;
   logic [ORDER_W-1:0] best_order_ff, best_order_in;
   logic [IDX_W-1:0]   lo_ff,         lo_in;
   logic [ORDER_W-1:0] lvl_ff,        lvl_in;

   // Result register
   logic               strobe_ff,     strobe_in;
   logic [31:0]        granted_ff,    granted_in;
   logic               status_ff,     status_in;

   // Tag memory ports
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   tag_type            wr_tag;
   logic [IDX_W-1:0]   rd0_addr;
   logic [IDX_W-1:0]   rd1_addr;
   tag_type            rd0_tag;
   tag_type            rd1_tag;

   // Shared fit unit and helpers
   logic [ORDER_W-1:0] split_order;
   logic [ORDER_W-1:0] fit_order;
   logic [CMP_W-1:0]   fit_bytes;
   logic               fit_ok;
   logic               scan_hit;
   logic [31:0]        rel_offset;
   logic               rel_in_pool;
   logic [IDX_W-1:0]   mid_idx;
   logic [LO_W-1:0]    next_lo;
   logic               pool_end;
   logic               lvl_end;
   logic               merge_ok;

   bpa_tag_ram #(
      .PAGE_COUNT (PAGE_COUNT)
   ) u_tag_ram (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_tag   (wr_tag),
      .rd0_addr (rd0_addr),
      .rd1_addr (rd1_addr),
      .rd0_tag  (rd0_tag),
      .rd1_tag  (rd1_tag)
   );

   // One compare serves both the scan (tag just read) and the split (next half down):
   // does a block of fit_order pages hold the request?
   assign split_order = best_order_ff - ORDER_W'(1);
   assign fit_order   = (state_ff == ST_SPLIT) ? split_order : rd0_tag.order;
   assign fit_bytes   = (CMP_W'(1) << PAGE_SHIFT) << fit_order;
   assign fit_ok      = (fit_bytes >= CMP_W'(want_ff));

   // Best fit: smallest order wins, strict compare keeps the lowest page on ties
   assign scan_hit = scan_live_ff && (rd0_tag.kind == KIND_FREE) && fit_ok &&
                     (!found_ff || (rd0_tag.order < best_order_ff));

   // Release address to page index; anything past the pool is dropped
   assign rel_offset  = addr_ff - base_ff;
   assign rel_in_pool = (rel_offset[31:PAGE_SHIFT+IDX_W] == '0);

   // Merge walk: pair (lo, mid) at level lvl, span 2 << lvl
   assign mid_idx  = lo_ff | (IDX_W'(1) << lvl_ff);
   assign next_lo  = {1'b0, lo_ff} + (LO_W'(2) << lvl_ff);
   assign pool_end = next_lo[IDX_W];
   assign lvl_end  = (lvl_ff == ORDER_W'(IDX_W - 1));
   assign merge_ok = (rd0_tag.kind == KIND_FREE) && (rd1_tag.kind == KIND_FREE) &&
                     (rd0_tag.order == lvl_ff) && (rd1_tag.order == lvl_ff);

   always_comb begin
      state_in      = state_ff;
      want_in       = want_ff;
      addr_in       = addr_ff;
      base_in       = base_ff;
      scan_idx_in   = scan_idx_ff;
      rd_idx_in     = rd_idx_ff;
      scan_live_in  = scan_live_ff;
      found_in      = found_ff;
      best_in       = best_ff;
      best_order_in = best_order_ff;
      lo_in         = lo_ff;
      lvl_in        = lvl_ff;
      strobe_in     = 1'b0;
      granted_in    = granted_ff;
      status_in     = status_ff;
      wr_en         = 1'b0;
      wr_addr       = best_ff;
      wr_tag        = '0;
      rd0_addr      = scan_idx_ff;
      rd1_addr      = mid_idx;

      // Base address is written only while idle
      if (csr_valid && csr_ready) begin
         base_in = csr_base_address;
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               want_in      = (req_request_bytes == '0) ? 16'd1 : req_request_bytes;
               addr_in      = req_block_address;
               scan_idx_in  = '0;
               scan_live_in = 1'b0;
               found_in     = 1'b0;
               state_in     = (req_command == CMD_ALLOC) ? ST_SCAN : ST_RELADDR;
            end
         end

         ST_SCAN: begin
            // Issue the next tag read while judging the one that just came back
            rd0_addr     = scan_idx_ff;
            rd_idx_in    = scan_idx_ff;
            scan_live_in = 1'b1;
            if (scan_hit) begin
               found_in      = 1'b1;
               best_in       = rd_idx_ff;
               best_order_in = rd0_tag.order;
            end
            if (scan_idx_ff == IDX_W'(PAGE_COUNT - 1)) begin
               state_in = ST_SCANEND;
            end else begin
               scan_idx_in = scan_idx_ff + IDX_W'(1);
            end
         end

         ST_SCANEND: begin
            if (scan_hit) begin
               found_in      = 1'b1;
               best_in       = rd_idx_ff;
               best_order_in = rd0_tag.order;
            end
            if (found_ff || scan_hit) begin
               state_in = ST_SPLIT;
            end else begin
               // No fit: tags untouched
               granted_in = '0;
               status_in  = STATUS_NO_FIT;
               strobe_in  = 1'b1;
               state_in   = ST_IDLE;
            end
         end

         ST_SPLIT: begin
            if ((best_order_ff != '0) && fit_ok) begin
               // Halve: the upper buddy becomes a free head
               wr_en         = 1'b1;
               wr_addr       = best_ff ^ (IDX_W'(1) << split_order);
               wr_tag.kind   = KIND_FREE;
               wr_tag.order  = split_order;
               best_order_in = split_order;
            end else begin
               wr_en        = 1'b1;
               wr_addr      = best_ff;
               wr_tag.kind  = KIND_ALLOC;
               wr_tag.order = best_order_ff;
               granted_in   = base_ff + (32'(best_ff) << PAGE_SHIFT);
               status_in    = STATUS_OK;
               strobe_in    = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         ST_RELADDR: begin
            best_in = rel_offset[PAGE_SHIFT +: IDX_W];
            lo_in   = '0;
            lvl_in  = '0;
            state_in = rel_in_pool ? ST_RELREAD : ST_MREAD;
         end

         ST_RELREAD: begin
            rd0_addr = best_ff;
            state_in = ST_RELFREE;
         end

         ST_RELFREE: begin
            // Only an allocated head is freed; order stays
            if (rd0_tag.kind == KIND_ALLOC) begin
               wr_en        = 1'b1;
               wr_addr      = best_ff;
               wr_tag.kind  = KIND_FREE;
               wr_tag.order = rd0_tag.order;
            end
            lo_in    = '0;
            lvl_in   = '0;
            state_in = ST_MREAD;
         end

         ST_MREAD: begin
            rd0_addr = lo_ff;
            rd1_addr = mid_idx;
            state_in = ST_MEVAL;
         end

         ST_MEVAL, ST_MCOVER: begin
            if ((state_ff == ST_MEVAL) && merge_ok) begin
               // Grow the lower buddy; drop the upper head next cycle
               wr_en        = 1'b1;
               wr_addr      = lo_ff;
               wr_tag.kind  = KIND_FREE;
               wr_tag.order = lvl_ff + ORDER_W'(1);
               state_in     = ST_MCOVER;
            end else begin
               if (state_ff == ST_MCOVER) begin
                  wr_en        = 1'b1;
                  wr_addr      = mid_idx;
                  wr_tag.kind  = KIND_COVERED;
                  wr_tag.order = '0;
               end
               // Advance to the next pair, the next level, or finish
               if (pool_end && lvl_end) begin
                  granted_in = '0;
                  status_in  = STATUS_OK;
                  strobe_in  = 1'b1;
                  state_in   = ST_IDLE;
               end else if (pool_end) begin
                  lo_in    = '0;
                  lvl_in   = lvl_ff + ORDER_W'(1);
                  state_in = ST_MREAD;
               end else begin
                  lo_in    = next_lo[IDX_W-1:0];
                  state_in = ST_MREAD;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         base_ff      <= BASE_RESET;
         strobe_ff    <= 1'b0;
         scan_live_ff <= 1'b0;
         found_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         base_ff      <= base_in;
         strobe_ff    <= strobe_in;
         scan_live_ff <= scan_live_in;
         found_ff     <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      want_ff       <= want_in;
      addr_ff       <= addr_in;
      scan_idx_ff   <= scan_idx_in;
      rd_idx_ff     <= rd_idx_in;
      best_ff       <= best_in;
      best_order_ff <= best_order_in;
      lo_ff         <= lo_in;
      lvl_ff        <= lvl_in;
      granted_ff    <= granted_in;
      status_ff     <= status_in;
   end

   assign busy                = (state_ff != ST_IDLE);
   assign csr_ready           = !busy;
   assign rsp_strobe          = strobe_ff;
   assign rsp_granted_address = granted_ff;
   assign rsp_status          = status_ff;

endmodule

/* sv/bpa_tag_ram.sv */
// Page tag memory: one write port, two registered read ports, reset image from valid bits.
module bpa_tag_ram
   import bpa_pkg::*;
#(
   parameter int PAGE_COUNT = DEF_PAGE_COUNT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          wr_en,
   input  logic [$clog2(PAGE_COUNT)-1:0] wr_addr,
   input  tag_type                       wr_tag,
   input  logic [$clog2(PAGE_COUNT)-1:0] rd0_addr,
   input  logic [$clog2(PAGE_COUNT)-1:0] rd1_addr,
   output tag_type                       rd0_tag,
   output tag_type                       rd1_tag
);

   localparam int IDX_W = $clog2(PAGE_COUNT);

   tag_type                 tag_mem_ff [PAGE_COUNT];
   logic [PAGE_COUNT-1:0]   valid_ff;
   tag_type                 rd0_data_ff;
   tag_type                 rd1_data_ff;
   logic                    rd0_valid_ff;
   logic                    rd1_valid_ff;
   logic                    rd0_zero_ff;
   logic                    rd1_zero_ff;
   tag_type                 head_tag;
   tag_type                 covered_tag;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         tag_mem_ff[wr_addr] <= wr_tag;
      end
      rd0_data_ff  <= tag_mem_ff[rd0_addr];
      rd1_data_ff  <= tag_mem_ff[rd1_addr];
      rd0_valid_ff <= valid_ff[rd0_addr];
      rd1_valid_ff <= valid_ff[rd1_addr];
      rd0_zero_ff  <= (rd0_addr == '0);
      rd1_zero_ff  <= (rd1_addr == '0);
   end

   // Unwritten entries read as the reset image: page 0 a free head of top order
   assign head_tag.kind     = KIND_FREE;
   assign head_tag.order    = ORDER_W'(IDX_W);
   assign covered_tag.kind  = KIND_COVERED;
   assign covered_tag.order = '0;

   assign rd0_tag = rd0_valid_ff ? rd0_data_ff : (rd0_zero_ff ? head_tag : covered_tag);
   assign rd1_tag = rd1_valid_ff ? rd1_data_ff : (rd1_zero_ff ? head_tag : covered_tag);

endmodule

/* bench/buddy_page_allocator_core_test.sv */
// Self-checking testbench for the buddy page allocator core: directed and random requests.
module buddy_page_allocator_core_test;
   import bpa_pkg::*;

   localparam int POOL_PAGES      = DEF_PAGE_COUNT;
   localparam int PAGE_BITS       = DEF_PAGE_SHIFT;
   localparam int TOP_ORDER       = $clog2(POOL_PAGES);
   localparam int PAGE_BYTES      = 1 << PAGE_BITS;
   localparam int POOL_BYTES      = POOL_PAGES * PAGE_BYTES;
   // Worst request: full tag scan plus splits, or a release with a merge per pair.
   localparam int SETTLE_CYCLES   = 4 * POOL_PAGES + 16;
   localparam int DRAIN_LIMIT     = 1000;
   localparam int REPORT_LIMIT    = 10;
   localparam int RANDOM_REQUESTS = 950;
   localparam int RANDOM_PHASES   = 5;

   typedef struct packed {
      logic [31:0] address;
      logic        status;
   } grant_type;

   // Block inputs start at known values; reset is held from time zero.
   logic        clock             = 1'b0;
   logic        reset             = 1'b1;
   logic        start             = 1'b0;
   logic        req_command       = CMD_ALLOC;
   logic [15:0] req_request_bytes = 16'd0;
   logic [31:0] req_block_address = 32'd0;
   logic        csr_valid         = 1'b0;
   logic [31:0] csr_base_address  = BASE_RESET;

   logic        busy;
   logic        rsp_strobe;
   logic [31:0] rsp_granted_address;
   logic        rsp_status;
   logic        csr_ready;

   // Mirror of the page tags and the base register, advanced at each accepted request.
   kind_type           page_kind  [POOL_PAGES];
   logic [ORDER_W-1:0] page_order [POOL_PAGES];
   logic [31:0]        pool_base;

   // Grants predicted but not yet seen on the result port, oldest first.
   grant_type pending_grants [$];
   int        failure_count = 0;
   bit        gaps_enabled  = 1'b1;

   buddy_page_allocator_core #(
      .PAGE_COUNT (POOL_PAGES),
      .PAGE_SHIFT (PAGE_BITS)
   ) u_dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_command         (req_command),
      .req_request_bytes   (req_request_bytes),
      .req_block_address   (req_block_address),
      .rsp_strobe          (rsp_strobe),
      .rsp_granted_address (rsp_granted_address),
      .rsp_status          (rsp_status),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_base_address    (csr_base_address)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Count every failure; print only the first few with their values.
   function automatic void report_failure(input string what, input logic [31:0] expected_value,
                                          input logic [31:0] actual_value);
      failure_count++;
      if (failure_count <= REPORT_LIMIT)
         $display("%0t: %s: expected %h, got %h", $time, what, expected_value, actual_value);
   endfunction

   // Bytes covered by a block of the given order.
   function automatic logic [31:0] block_span(input logic [ORDER_W-1:0] ord);
      return (32'd1 << ord) << PAGE_BITS;
   endfunction

   // Put the mirror into the post-reset state: one free block of top order at page 0.
   function automatic void reset_pool_model();
      for (int p = 0; p < POOL_PAGES; p++) begin
         page_kind[p]  = KIND_COVERED;
         page_order[p] = '0;
      end
      page_kind[0]  = KIND_FREE;
      page_order[0] = ORDER_W'(TOP_ORDER);
      pool_base     = BASE_RESET;
   endfunction

   // Best fit: smallest free block that holds the request, lowest page on ties.
   function automatic grant_type predict_allocate(input logic [15:0] bytes);
      logic [16:0]        want;
      logic               found;
      int                 best;
      int                 buddy;
      logic [31:0]        best_span;
      logic [ORDER_W-1:0] ord;
      grant_type          reply;
      want = (bytes == 16'd0) ? 17'd1 : {1'b0, bytes};
      found = 1'b0;
      best = 0;
      best_span = '0;
      reply.address = '0;
      reply.status = STATUS_OK;
      for (int p = 0; p < POOL_PAGES; p++) begin
         if (page_kind[p] == KIND_FREE && block_span(page_order[p]) >= want &&
             (!found || block_span(page_order[p]) < best_span)) begin
            found = 1'b1;
            best = p;
            best_span = block_span(page_order[p]);
         end
      end
      if (!found) begin
         reply.status = STATUS_NO_FIT;
         return reply;
      end
      // Halve while the lower half still holds the request; the upper half goes free.
      ord = page_order[best];
      while (ord > 0 && block_span(ord - 1'b1) >= want) begin
         ord = ord - 1'b1;
         buddy = best ^ (1 << ord);
         if (buddy < POOL_PAGES) begin
            page_kind[buddy]  = KIND_FREE;
            page_order[buddy] = ord;
         end
      end
      page_kind[best]  = KIND_ALLOC;
      page_order[best] = ord;
      reply.address = pool_base + (32'(best) << PAGE_BITS);
      return reply;
   endfunction

   // Free an allocated head if the address names one, then merge buddies bottom-up.
   function automatic void predict_release(input logic [31:0] addr);
      logic [31:0] page;
      int          span;
      int          mid;
      page = (addr - pool_base) >> PAGE_BITS;
      if (page < POOL_PAGES) begin
         if (page_kind[page] == KIND_ALLOC)
            page_kind[page] = KIND_FREE;
      end
      for (int k = 1; (1 << k) <= POOL_PAGES; k++) begin
         span = 1 << k;
         for (int lo = 0; lo + span <= POOL_PAGES; lo += span) begin
            mid = lo + span / 2;
            if (page_kind[lo] == KIND_FREE && page_kind[mid] == KIND_FREE &&
                page_order[lo] == k - 1 && page_order[mid] == k - 1) begin
               page_order[lo] = ORDER_W'(k);
               for (int p = lo + 1; p < lo + span; p++) begin
                  page_kind[p]  = KIND_COVERED;
                  page_order[p] = '0;
               end
            end
         end
      end
   endfunction

   // Hold until every predicted grant has come back.
   task automatic wait_for_grants();
      while (pending_grants.size() != 0)
         @(posedge clock);
   endtask

   // Drop start, drain the results and let the block settle before touching the CSR.
   task automatic quiesce_sender();
      start <= 1'b0;
      wait_for_grants();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Sender gap: now and then a random pause, sometimes only after the outstanding result is back.
   task automatic pause_sender();
      if (gaps_enabled && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         if ($urandom_range(0, 1) == 1)
            wait_for_grants();
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   // Present one request, hold it until accepted, then predict its grant.
   // Start stays high on return unless the sender pauses, so back-to-back requests need no extra edge.
   task automatic issue_request(input logic cmd, input logic [15:0] bytes,
                                input logic [31:0] addr);
      grant_type reply;
      start             <= 1'b1;
      req_command       <= cmd;
      req_request_bytes <= bytes;
      req_block_address <= addr;
      do
         @(posedge clock);
      while (busy);
      if (cmd == CMD_ALLOC) begin
         reply = predict_allocate(bytes);
      end else begin
         predict_release(addr);
         reply.address = '0;
         reply.status = STATUS_OK;
      end
      pending_grants.push_back(reply);
      pause_sender();
   endtask

   // The unused field of each command carries random bits.
   task automatic request_alloc(input logic [15:0] bytes);
      issue_request(CMD_ALLOC, bytes, $urandom());
   endtask

   task automatic request_release(input logic [31:0] addr);
      issue_request(CMD_RELEASE, 16'($urandom()), addr);
   endtask

   // Write the base register; call only with the block idle.
   task automatic write_base(input logic [31:0] value);
      csr_valid        <= 1'b1;
      csr_base_address <= value;
      do
         @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      pool_base = value;
   endtask

   // Sizes mostly land in one order's range; some are zero, exact, or beyond the pool.
   function automatic logic [15:0] pick_request_bytes();
      int r;
      int ord;
      int hi;
      r = $urandom_range(0, 19);
      if (r == 0)
         return 16'd0;
      if (r == 1)
         return 16'($urandom());
      if (r == 2)
         return 16'($urandom_range(POOL_BYTES + 1, 65535));
      ord = $urandom_range(0, TOP_ORDER);
      hi = PAGE_BYTES << ord;
      if (r == 3)
         return 16'(hi);
      if (r == 4)
         return 16'(hi / 2 + 1);
      return 16'($urandom_range((ord == 0) ? 1 : hi / 2 + 1, hi));
   endfunction

   // Take the whole pool, confirm nothing else fits, give it back.
   task automatic test_whole_pool();
      request_alloc(16'(POOL_BYTES));
      request_alloc(16'd0);                          // zero size still needs a page
      request_alloc(16'hFFFF);                       // never fits the pool
      request_release(pool_base + 32'hFFF);          // offset inside the page ignored
   endtask

   // Split down to the smallest block, exercise ignored releases, merge back up.
   task automatic test_split_merge_release();
      request_alloc(16'd0);                          // zero size -> one page at page 0
      request_alloc(16'd1);
      request_alloc(16'(PAGE_BYTES + 1));            // one byte over a page -> two pages
      request_alloc(16'(4 * PAGE_BYTES));
      request_alloc(16'd1);                          // pool full
      request_release(pool_base + 3 * PAGE_BYTES);   // covered page: no change
      request_release(pool_base + PAGE_BYTES);
      request_release(pool_base + PAGE_BYTES);       // already a free head: no change
      request_release(pool_base - PAGE_BYTES);       // below the pool, wraps far out
      request_release(pool_base + POOL_BYTES);       // first page past the pool
      request_release(pool_base);
      request_release(pool_base + 2 * PAGE_BYTES);
      request_release(pool_base + 4 * PAGE_BYTES);   // merges back to one block
      request_alloc(16'(POOL_BYTES + 1));
      request_alloc(16'(PAGE_BYTES));
      request_release(32'hFFFF_FFFF);
      request_release(32'h0000_0000);
      request_release(pool_base);
   endtask

   // Base register at its extremes, with grants wrapping past the top of the address space.
   task automatic test_base_extremes();
      quiesce_sender();
      write_base(32'h0000_0000);
      request_alloc(16'(2 * PAGE_BYTES));
      quiesce_sender();
      write_base(32'hFFFF_F000);
      request_alloc(16'(PAGE_BYTES));                // lands past the wrap
      request_release(pool_base + 32'(2 * PAGE_BYTES));
      request_release(pool_base);
      quiesce_sender();
      write_base(32'hFFFF_FFFF);
      request_alloc(16'd1);
      request_release(32'hFFFF_FFFF);
   endtask

   // Random traffic over several base settings; most releases name live heads.
   task automatic test_random_traffic();
      logic [31:0] phase_base [RANDOM_PHASES];
      int          counted;
      int          roll;
      int          page;
      int          heads [$];
      logic [31:0] addr;
      phase_base[0] = BASE_RESET;
      phase_base[1] = $urandom();
      phase_base[2] = 32'hFFFF_A000;
      phase_base[3] = 32'h0000_0000;
      phase_base[4] = $urandom();
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         quiesce_sender();
         write_base(phase_base[ph]);
         counted = 0;
         while (counted < RANDOM_REQUESTS / RANDOM_PHASES) begin
            // Alternate stretches with and without gaps; the final phase runs flat out.
            gaps_enabled = (ph != RANDOM_PHASES - 1) && ((counted / 40) % 2 == 0);
            heads.delete();
            for (int p = 0; p < POOL_PAGES; p++)
               if (page_kind[p] == KIND_ALLOC)
                  heads.push_back(p);
            roll = $urandom_range(0, 99);
            if (roll >= 88) begin
               // Noise: arbitrary address, or any page near the pool with offset bits.
               if ($urandom_range(0, 1) == 1)
                  addr = $urandom();
               else
                  addr = pool_base + ($urandom_range(0, 2 * POOL_PAGES - 1) << PAGE_BITS) +
                         $urandom_range(0, PAGE_BYTES - 1);
               request_release(addr);
               counted++;
            end else if (roll >= 55 && heads.size() != 0) begin
               page = heads[$urandom_range(0, heads.size() - 1)];
               addr = pool_base + (32'(page) << PAGE_BITS);
               if ($urandom_range(0, 2) == 0)
                  addr = addr + $urandom_range(0, PAGE_BYTES - 1);
               request_release(addr);
               counted++;
            end else begin
               request_alloc(pick_request_bytes());
               counted++;
            end
         end
      end
   endtask

   // Compare each strobed result with the oldest prediction, field by field.
   always @(posedge clock) begin : check_grants
      grant_type want_grant;
      if (!reset && rsp_strobe) begin
         if (pending_grants.size() == 0) begin
            report_failure("result with no request outstanding", 32'd0, rsp_granted_address);
         end else begin
            want_grant = pending_grants.pop_front();
            if (rsp_granted_address !== want_grant.address)
               report_failure("granted_address", want_grant.address, rsp_granted_address);
            if (rsp_status !== want_grant.status)
               report_failure("status", 32'(want_grant.status), 32'(rsp_status));
         end
      end
   end

   initial begin : run_tests
      int drain_cycles;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      reset_pool_model();
      test_whole_pool();
      test_split_merge_release();
      test_base_extremes();
      test_random_traffic();
      // Release start, drain with a bound, then give stray results time to show.
      start <= 1'b0;
      drain_cycles = 0;
      while (pending_grants.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
         @(posedge clock);
         drain_cycles++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_grants.size() != 0)
         report_failure("results never returned", 32'd0, 32'(pending_grants.size()));
      if (failure_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #5_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

/* sim.f */
sv/bpa_pkg.sv
sv/bpa_tag_ram.sv
sv/buddy_page_allocator_core.sv
bench/buddy_page_allocator_core_test.sv
